/* rtl/dllm_pkg.sv */
// Shared constants and types for the decaying load and latency monitor.
// No dependencies; the top level takes its widths from here, the divider does not.
package dllm_pkg;

  // Field widths of the input and result beats.
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned TIME_W  = 31;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned LAT_W   = 20;
  localparam int unsigned OUT_W   = 29;

  // Configuration port geometry.
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // Largest value a result field can carry.
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_AVG  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_PEAK = 1'b1;

  // Command codes; the remaining codes behave as a poll.
  typedef enum logic [CMD_W-1:0] {
    CMD_COUNT   = 3'd0,
    CMD_LATENCY = 3'd1,
    CMD_SAMPLE  = 3'd2,
    CMD_BATCH   = 3'd3,
    CMD_POLL    = 3'd4
  } cmd_e;

endpackage

/* rtl/dllm_div.sv */
// Iterative restoring divider shared by the batch peak raise and the result averages.
// Retires two quotient bits per cycle; standalone, no package dependency.
module dllm_div #(
  parameter int unsigned QW = 32,
  parameter int unsigned VW = 31
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [QW-1:0] dividend_i,
  input  logic [VW-1:0] rem_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [QW-1:0] quot_o
);

  localparam int unsigned NS   = QW / 2;
  localparam int unsigned CNTW = $clog2(NS + 1);

  logic            busy_q;
  logic [CNTW-1:0] cnt_q;
  logic [VW-1:0]   rem_q;
  logic [QW-1:0]   dvd_q;
  logic [VW-1:0]   dvs_q;

  logic [VW-1:0]   rem_d;
  logic [QW-1:0]   dvd_d;
  logic [VW:0]     trial;
  logic            qbit;

  // Two restoring steps: shift in the next dividend bit, subtract if it fits.
  // The dividend register fills with quotient bits from the bottom.
  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    trial = '0;
    qbit  = 1'b0;
    for (int k = 0; k < 2; k++) begin
      trial = {rem_d, dvd_d[QW-1]};
      qbit  = (trial >= {1'b0, dvs_q});
      if (qbit) begin
        trial = trial - {1'b0, dvs_q};
      end
      rem_d = trial[VW-1:0];
      dvd_d = {dvd_d[QW-2:0], qbit};
    end
  end

  // Step counter and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNTW'(NS);
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNTW'(1);
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = dvd_q;

endmodule

/* rtl/decaying_load_latency_monitor.sv */
// Top level of the decaying load and latency monitor: sequencer, accumulators, multiplier.
// Depends on dllm_pkg and on the shared divider dllm_div.
//
//   channel  signals                                    direction
//   in       in_valid_i / in_ready_o, cmd .. latency_ms  into block
//   out      out_valid_o / out_ready_i, load_count ..    out of block
//   cfg      cfg_we_i, cfg_idx_i, cfg_data_i             into block, write only
//
// An item's time is set mostly by the divider: up to three divisions run one after another
// (the batch quotient, the average and the peak), and each elapsed second adds one decay
// step. in_ready_o is high only between items.
// Reset clears the targets, the timestamp and all accumulators.
// A finished result waits in the output register; the next item is taken meanwhile
// and is only held back at its last cycle until that result leaves.
module decaying_load_latency_monitor #(
  parameter int unsigned STALE_WINDOW = 8,
  parameter int unsigned ACC_WIDTH    = 31
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [dllm_pkg::CMD_W-1:0]       cmd_i,
  input  logic [dllm_pkg::TIME_W-1:0]      now_seconds_i,
  input  logic [dllm_pkg::CNT_W-1:0]       sample_count_i,
  input  logic [dllm_pkg::LAT_W-1:0]       latency_ms_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [dllm_pkg::OUT_W-1:0]       load_count_o,
  output logic [dllm_pkg::OUT_W-1:0]       latency_avg_o,
  output logic [dllm_pkg::OUT_W-1:0]       latency_peak_o,
  output logic                             overloaded_o,
  input  logic                             cfg_we_i,
  input  logic [dllm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dllm_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int unsigned AW  = ACC_WIDTH;
  localparam int unsigned LW  = dllm_pkg::LAT_W;
  localparam int unsigned TW  = dllm_pkg::TIME_W;
  localparam int unsigned NW  = dllm_pkg::CNT_W;
  localparam int unsigned OW  = dllm_pkg::OUT_W;
  localparam int unsigned MW  = LW + 2;
  localparam int unsigned PW  = AW + MW;
  localparam int unsigned QW  = AW + (AW % 2);
  localparam int unsigned SW  = ((AW > LW) ? AW : LW) + 1;
  localparam int unsigned CW  = (QW > dllm_pkg::CFG_W) ? QW : dllm_pkg::CFG_W;
  localparam int unsigned SCW = $clog2(STALE_WINDOW + 1);
  localparam logic [AW-1:0] ACC_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECAY,
    ST_APPLY,
    ST_MUL,
    ST_CAND,
    ST_BATCH_WAIT,
    ST_AVG_START,
    ST_AVG_WAIT,
    ST_PEAK_WAIT,
    ST_FINISH
  } st_e;

  st_e                        state_q;
  dllm_pkg::cmd_e             cmd_q;
  logic [NW-1:0]              n_q;
  logic [LW-1:0]              lat_q;
  logic [MW-1:0]              m_q;
  logic [PW-1:0]              prod_q;
  logic [SCW-1:0]             step_q;
  logic [TW-1:0]              last_q;
  logic [AW-1:0]              count_q;
  logic [AW-1:0]              event_q;
  logic [AW-1:0]              sum_q;
  logic [AW-1:0]              peak_q;
  logic [QW-1:0]              avg_q;
  logic [QW-1:0]              pkr_q;
  logic [dllm_pkg::CFG_W-1:0] target_avg_q;
  logic [dllm_pkg::CFG_W-1:0] target_peak_q;
  logic                       out_valid_q;
  logic [OW-1:0]              load_count_q;
  logic [OW-1:0]              latency_avg_q;
  logic [OW-1:0]              latency_peak_q;
  logic                       overloaded_q;

  logic                       in_fire;
  logic                       time_back;
  logic                       time_stale;
  logic [TW-1:0]              elapsed;
  logic [LW-1:0]              lat_eff;
  logic                       need_mul;
  logic [MW-1:0]              prod_hi;
  logic [AW-1:0]              prod_lo;
  logic                       batch_sat;
  logic [AW-1:0]              lat_cand;
  logic                       div_start;
  logic [QW-1:0]              div_dividend;
  logic [AW-1:0]              div_rem;
  logic [AW-1:0]              div_divisor;
  logic                       div_done;
  logic [QW-1:0]              div_quot;
  logic [CW-1:0]              avg_w;
  logic [CW-1:0]              pk_w;
  logic [CW-1:0]              cnt_w;
  logic                       over;

  // Saturating add at the accumulator width.
  function automatic logic [AW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW-1:0] s;
    s = a + b;
    if (s >= SW'(ACC_MAX)) begin
      return ACC_MAX;
    end
    return AW'(s);
  endfunction

  // One second of decay on a count: lose a quarter, rounded up.
  function automatic logic [AW-1:0] decay_up(input logic [AW-1:0] v);
    logic [AW:0] t;
    t = {1'b0, v} + (AW+1)'(3);
    return v - AW'(t[AW:2]);
  endfunction

  // One second of decay on a latency accumulator: lose a quarter, rounded down.
  function automatic logic [AW-1:0] decay_dn(input logic [AW-1:0] v);
    return v - AW'(v[AW-1:2]);
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Time checks against the last update.
  assign time_back  = now_seconds_i < last_q;
  assign time_stale = {1'b0, now_seconds_i} > ({1'b0, last_q} + (TW+1)'(STALE_WINDOW));
  assign elapsed    = now_seconds_i - last_q;

  // A latency of one millisecond counts as zero for the single commands.
  always_comb begin
    lat_eff = lat_q;
    if ((cmd_q == dllm_pkg::CMD_LATENCY || cmd_q == dllm_pkg::CMD_SAMPLE) &&
        lat_q == LW'(1)) begin
      lat_eff = '0;
    end
  end

  assign need_mul = (cmd_q == dllm_pkg::CMD_LATENCY) || (cmd_q == dllm_pkg::CMD_SAMPLE) ||
                    ((cmd_q == dllm_pkg::CMD_BATCH) && (n_q != '0));

  // Peak candidate: events times four times latency, saturated; a batch divides it by the batch size.
  assign prod_hi   = prod_q[PW-1:AW];
  assign prod_lo   = prod_q[AW-1:0];
  assign batch_sat = prod_hi >= MW'(n_q);
  assign lat_cand  = (prod_hi != '0) ? ACC_MAX : prod_lo;

  // Divider operand selection and launch. For a batch the bits of the product above
  // the dividend width seed the partial remainder; they stay below the batch size.
  always_comb begin
    div_dividend = QW'(sum_q[AW-1:2]);
    div_rem      = '0;
    div_divisor  = event_q;
    case (state_q)
      ST_CAND: begin
        div_dividend = prod_q[QW-1:0];
        div_rem      = AW'(prod_q[PW-1:QW]);
        div_divisor  = AW'(n_q);
      end
      ST_AVG_WAIT: begin
        div_dividend = QW'(peak_q[AW-1:2]);
      end
      default: begin
        div_dividend = QW'(sum_q[AW-1:2]);
      end
    endcase
  end

  assign div_start = ((state_q == ST_CAND) && (cmd_q == dllm_pkg::CMD_BATCH) && !batch_sat) ||
                     ((state_q == ST_AVG_START) && (event_q != '0)) ||
                     ((state_q == ST_AVG_WAIT) && div_done);

  dllm_div #(
    .QW(QW),
    .VW(AW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .rem_i      (div_rem),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Overload check on the unsaturated quotients.
  assign avg_w = CW'(avg_q);
  assign pk_w  = CW'(pkr_q);
  assign cnt_w = CW'(count_q[AW-1:2]);
  assign over  = ((target_peak_q != '0) && (pk_w > CW'(target_peak_q))) ||
                 ((target_avg_q != '0) && (avg_w > CW'(target_avg_q)));

  // Sequencer, accumulators and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cmd_q          <= dllm_pkg::CMD_POLL;
      n_q            <= '0;
      lat_q          <= '0;
      m_q            <= '0;
      prod_q         <= '0;
      step_q         <= '0;
      last_q         <= '0;
      count_q        <= '0;
      event_q        <= '0;
      sum_q          <= '0;
      peak_q         <= '0;
      avg_q          <= '0;
      pkr_q          <= '0;
      target_avg_q   <= '0;
      target_peak_q  <= '0;
      out_valid_q    <= 1'b0;
      load_count_q   <= '0;
      latency_avg_q  <= '0;
      latency_peak_q <= '0;
      overloaded_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dllm_pkg::REG_TARGET_AVG:  target_avg_q  <= cfg_data_i;
          dllm_pkg::REG_TARGET_PEAK: target_peak_q <= cfg_data_i;
          default: begin
          end
        endcase
      end

      // A taken result empties the output register; in ST_FINISH the reload decides.
      if (out_valid_q && out_ready_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        // Take the beat and bring the accumulators to the current second, or clear them if time ran back or went stale.
        ST_IDLE: begin
          if (in_fire) begin
            cmd_q  <= dllm_pkg::cmd_e'(cmd_i);
            n_q    <= sample_count_i;
            lat_q  <= latency_ms_i;
            last_q <= now_seconds_i;
            step_q <= '0;
            state_q <= ST_APPLY;
            if (now_seconds_i != last_q) begin
              if (time_back || time_stale) begin
                count_q <= '0;
                event_q <= '0;
                sum_q   <= '0;
                peak_q  <= '0;
              end else begin
                step_q  <= SCW'(elapsed);
                state_q <= ST_DECAY;
              end
            end
          end
        end

        // One elapsed second per cycle.
        ST_DECAY: begin
          count_q <= decay_up(count_q);
          event_q <= decay_up(event_q);
          sum_q   <= decay_dn(sum_q);
          peak_q  <= decay_dn(peak_q);
          step_q  <= step_q - SCW'(1);
          if (step_q == SCW'(1)) begin
            state_q <= ST_APPLY;
          end
        end

        // Apply the command to the accumulators.
        ST_APPLY: begin
          case (cmd_q)
            dllm_pkg::CMD_COUNT: begin
              count_q <= sat_add(SW'(count_q), SW'(1));
            end
            dllm_pkg::CMD_LATENCY: begin
              event_q <= sat_add(SW'(event_q), SW'(1));
              sum_q   <= sat_add(SW'(sum_q), SW'(lat_eff));
              peak_q  <= sat_add(SW'(peak_q), SW'(lat_eff));
            end
            dllm_pkg::CMD_SAMPLE: begin
              count_q <= sat_add(SW'(count_q), SW'(1));
              event_q <= sat_add(SW'(event_q), SW'(1));
              sum_q   <= sat_add(SW'(sum_q), SW'(lat_eff));
              peak_q  <= sat_add(SW'(peak_q), SW'(lat_eff));
            end
            dllm_pkg::CMD_BATCH: begin
              count_q <= sat_add(SW'(count_q), SW'(n_q));
              event_q <= sat_add(SW'(event_q), SW'(n_q));
              sum_q   <= sat_add(SW'(sum_q), SW'(lat_eff));
              peak_q  <= sat_add(SW'(peak_q), SW'(lat_eff));
            end
            default: begin
            end
          endcase
          m_q     <= {lat_eff, 2'b00};
          state_q <= need_mul ? ST_MUL : ST_AVG_START;
        end

        // Events times four times latency, at full width.
        ST_MUL: begin
          prod_q  <= PW'(event_q) * PW'(m_q);
          state_q <= ST_CAND;
        end

        // Raise the peak, or hand a batch quotient to the divider.
        ST_CAND: begin
          if (cmd_q == dllm_pkg::CMD_BATCH) begin
            if (batch_sat) begin
              peak_q  <= ACC_MAX;
              state_q <= ST_AVG_START;
            end else begin
              state_q <= ST_BATCH_WAIT;
            end
          end else begin
            if (peak_q < lat_cand) begin
              peak_q <= lat_cand;
            end
            state_q <= ST_AVG_START;
          end
        end

        ST_BATCH_WAIT: begin
          if (div_done) begin
            if (peak_q < div_quot[AW-1:0]) begin
              peak_q <= div_quot[AW-1:0];
            end
            state_q <= ST_AVG_START;
          end
        end

        // Averages are zero when no latency events remain.
        ST_AVG_START: begin
          if (event_q == '0) begin
            avg_q   <= '0;
            pkr_q   <= '0;
            state_q <= ST_FINISH;
          end else begin
            state_q <= ST_AVG_WAIT;
          end
        end

        ST_AVG_WAIT: begin
          if (div_done) begin
            avg_q   <= div_quot;
            state_q <= ST_PEAK_WAIT;
          end
        end

        ST_PEAK_WAIT: begin
          if (div_done) begin
            pkr_q   <= div_quot;
            state_q <= ST_FINISH;
          end
        end

        // Load the result once the output register is free.
        ST_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            load_count_q   <= (cnt_w > CW'(dllm_pkg::OUT_MAX)) ? dllm_pkg::OUT_MAX
                                                               : cnt_w[OW-1:0];
            latency_avg_q  <= (avg_w > CW'(dllm_pkg::OUT_MAX)) ? dllm_pkg::OUT_MAX
                                                               : avg_w[OW-1:0];
            latency_peak_q <= (pk_w > CW'(dllm_pkg::OUT_MAX)) ? dllm_pkg::OUT_MAX
                                                              : pk_w[OW-1:0];
            overloaded_q   <= over;
            out_valid_q    <= 1'b1;
            state_q        <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign load_count_o   = load_count_q;
  assign latency_avg_o  = latency_avg_q;
  assign latency_peak_o = latency_peak_q;
  assign overloaded_o   = overloaded_q;

  // The block is busy in the cycle after it takes a beat.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input accepted on the cycle after a beat");

  // The timestamp follows every accepted beat.
  a_time_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (last_q == $past(now_seconds_i)))
    else $error("last update time not taken from the beat");

  // Divider results only arrive while the sequencer waits for them.
  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_BATCH_WAIT || state_q == ST_AVG_WAIT ||
                  state_q == ST_PEAK_WAIT))
    else $error("divider finished outside a wait state");

  // A pending result is never overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_valid_q && !out_ready_i) |=>
      (state_q == ST_FINISH && out_valid_q))
    else $error("result register reloaded while a beat was pending");

endmodule
